// ----- sv/hma_pkg.sv -----
// shared constants, types and helper functions of the hull moving average block
package hma_pkg;

    localparam int PERIOD_MAX     = 256;
    localparam int PERIOD_BITS    = 9;
    localparam int ADDR_BITS      = $clog2(PERIOD_MAX);
    localparam int ROOT_MAX       = 16;
    localparam int ROOT_ADDR_BITS = $clog2(ROOT_MAX);
    localparam int ROOT_BITS      = $clog2(ROOT_MAX + 1);
    localparam int SAMPLE_BITS    = 32;
    localparam int DIFF_BITS      = SAMPLE_BITS + 2;
    localparam int FLAT_BITS      = 40;
    localparam int WSUM_BITS      = 48;
    localparam int SEEN_BITS      = 10;
    localparam int SEEN_CAP       = 1023;
    localparam int DIVISOR_BITS   = 17;
    localparam int DIV_STEPS      = WSUM_BITS / 2;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
    localparam int PERIOD_RESET   = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_DF_GO,
        S_DF_WAIT,
        S_DH_GO,
        S_DH_WAIT,
        S_DIFF,
        S_DR_GO,
        S_DR_WAIT,
        S_OUT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        DIV_FULL,
        DIV_HALF,
        DIV_ROOT
    } t_div_sel;

    typedef struct packed {
        logic     cfg_we;
        logic     load;
        logic     warm;
        logic     acc;
        logic     div_go;
        t_div_sel div_sel;
        logic     cap_full;
        logic     cap_half;
        logic     diff;
        logic     emit;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic warm;
        logic emit;
        logic div_done;
        logic out_free;
    } t_status;

    // floor of the square root, at least 1 and capped at ROOT_MAX
    function automatic logic [ROOT_BITS-1:0] isqrt(input logic [PERIOD_BITS-1:0] n);
        logic [ROOT_BITS-1:0] r;
        r = ROOT_BITS'(1);
        for (int k = 1; k <= ROOT_MAX; k++) begin
            if (k * k <= int'(n)) begin
                r = ROOT_BITS'(k);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/hma_div.sv -----
// iterative signed divider, two quotient bits per cycle, truncating toward zero
module hma_div import hma_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WSUM_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]     i_divisor,
    output logic                        o_done,
    output logic signed [WSUM_BITS-1:0] o_quot
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [WSUM_BITS-1:0]    r_work;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_div;
    logic                    r_neg;
    logic signed [WSUM_BITS-1:0] r_quot;

    logic [WSUM_BITS-1:0]    n_work;
    logic [DIVISOR_BITS-1:0] n_rem;
    logic [WSUM_BITS-1:0]    mag;

    assign mag = i_dividend[WSUM_BITS-1] ? WSUM_BITS'(-i_dividend) : WSUM_BITS'(i_dividend);

    always_comb begin
        logic [DIVISOR_BITS:0] rem_ext;
        n_rem  = r_rem;
        n_work = r_work;
        for (int s = 0; s < 2; s++) begin
            rem_ext = {n_rem, n_work[WSUM_BITS-1]};
            n_work  = {n_work[WSUM_BITS-2:0], 1'b0};
            if (rem_ext >= {1'b0, r_div}) begin
                rem_ext   = rem_ext - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = rem_ext[DIVISOR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_work <= mag;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[WSUM_BITS-1];
            end else if (r_busy) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= r_neg ? $signed(-n_work) : $signed(n_work);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- sv/hma_dp.sv -----
// datapath: running sums, history memories, divider and result register
module hma_dp import hma_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic [PERIOD_BITS-1:0]        i_cfg_period,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_value
);

    logic [PERIOD_BITS-1:0]        r_period;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [SEEN_BITS-1:0]          r_i;
    logic [SEEN_BITS-1:0]          r_seen;
    logic [ADDR_BITS-1:0]          r_samp_pos;
    logic [ROOT_ADDR_BITS-1:0]     r_diff_pos;
    logic signed [FLAT_BITS-1:0]   r_full_f, r_half_f, r_root_f;
    logic signed [WSUM_BITS-1:0]   r_full_w, r_half_w, r_root_w;
    logic signed [SAMPLE_BITS-1:0] r_old_full, r_old_half;
    logic signed [SAMPLE_BITS-1:0] r_wma_full, r_wma_half;
    logic signed [DIFF_BITS-1:0]   r_diff, r_old_diff;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;

    logic signed [SAMPLE_BITS-1:0] samp_mem [PERIOD_MAX];
    logic signed [DIFF_BITS-1:0]   diff_mem [ROOT_MAX];

    logic [PERIOD_BITS-1:0]    n, h, n_m1, h_m1;
    logic [ROOT_BITS-1:0]      r, r_m1;
    logic [2*PERIOD_BITS-1:0]  prod_n, prod_h, prod_r;
    logic [DIVISOR_BITS-1:0]   wn, wh, wr;
    logic [PERIOD_BITS-1:0]    wt_full, wt_half, wt_a, wt_b;
    logic signed [SAMPLE_BITS+PERIOD_BITS:0] p_a, p_b;
    logic signed [DIFF_BITS-1:0]   d;
    logic signed [DIFF_BITS+ROOT_BITS:0] p_d;
    logic signed [SAMPLE_BITS-1:0] half_old;
    logic signed [DIFF_BITS-1:0]   diff_old;
    logic [ADDR_BITS-1:0]      addr_full, addr_half;
    logic [ROOT_ADDR_BITS-1:0] addr_diff;
    logic signed [WSUM_BITS-1:0]   div_num;
    logic [DIVISOR_BITS-1:0]   div_den;
    logic                      div_done;
    logic signed [WSUM_BITS-1:0]   div_q;
    logic                      out_take;
    logic                      half_in;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WSUM_BITS-1:0] v);
        logic signed [WSUM_BITS-1:0] hi, lo;
        hi = WSUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - WSUM_BITS'(1);
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    // period clamp and derived window lengths
    always_comb begin
        if (r_period < PERIOD_BITS'(2))               n = PERIOD_BITS'(2);
        else if (r_period > PERIOD_BITS'(PERIOD_MAX)) n = PERIOD_BITS'(PERIOD_MAX);
        else                                          n = r_period;
    end
    assign h      = n >> 1;
    assign r      = isqrt(n);
    assign n_m1   = n - PERIOD_BITS'(1);
    assign h_m1   = h - PERIOD_BITS'(1);
    assign r_m1   = r - ROOT_BITS'(1);
    assign prod_n = (2*PERIOD_BITS)'(n) * (2*PERIOD_BITS)'(n + PERIOD_BITS'(1));
    assign prod_h = (2*PERIOD_BITS)'(h) * (2*PERIOD_BITS)'(h + PERIOD_BITS'(1));
    assign prod_r = (2*PERIOD_BITS)'(r) * (2*PERIOD_BITS)'(r + ROOT_BITS'(1));
    assign wn     = prod_n[DIVISOR_BITS:1];
    assign wh     = prod_h[DIVISOR_BITS:1];
    assign wr     = prod_r[DIVISOR_BITS:1];

    assign addr_full = r_samp_pos - n_m1[ADDR_BITS-1:0];
    assign addr_half = r_samp_pos - h_m1[ADDR_BITS-1:0];
    assign addr_diff = r_diff_pos - r_m1[ROOT_ADDR_BITS-1:0];

    // window of one: the oldest entry is the one just written
    assign half_old = (h == PERIOD_BITS'(1)) ? r_x : r_old_half;
    assign diff_old = (r == ROOT_BITS'(1)) ? r_diff : r_old_diff;

    // warm-up weights
    assign wt_full = r_i[PERIOD_BITS-1:0] + PERIOD_BITS'(1);
    assign wt_half = wt_full - (n - h);
    assign half_in = (r_i >= SEEN_BITS'(n - h));
    assign wt_a    = i_cmd.warm ? wt_full : n;
    assign wt_b    = i_cmd.warm ? wt_half : h;
    assign p_a     = r_x * $signed({1'b0, wt_a});
    assign p_b     = r_x * $signed({1'b0, wt_b});

    assign d   = (DIFF_BITS'(r_wma_half) <<< 1) - DIFF_BITS'(r_wma_full);
    assign p_d = d * $signed({1'b0, r});

    always_comb begin
        case (i_cmd.div_sel)
            DIV_FULL: begin div_num = r_full_w; div_den = wn; end
            DIV_HALF: begin div_num = r_half_w; div_den = wh; end
            DIV_ROOT: begin div_num = r_root_w; div_den = wr; end
            default:  begin div_num = r_full_w; div_den = wn; end
        endcase
    end

    hma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign out_take = r_out_valid && !i_out_stall;

    assign o_status.warm     = (r_i < SEEN_BITS'(n_m1));
    assign o_status.emit     = (r_i >= SEEN_BITS'(n) + SEEN_BITS'(r) - SEEN_BITS'(2));
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            samp_mem[r_samp_pos] <= i_sample;
            r_old_full           <= samp_mem[addr_full];
            r_old_half           <= samp_mem[addr_half];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            diff_mem[r_diff_pos] <= d;
            r_old_diff           <= diff_mem[addr_diff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_BITS'(PERIOD_RESET);
            r_seen      <= '0;
            r_samp_pos  <= '0;
            r_diff_pos  <= '0;
            r_full_f    <= '0;
            r_half_f    <= '0;
            r_root_f    <= '0;
            r_full_w    <= '0;
            r_half_w    <= '0;
            r_root_w    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_period   <= i_cfg_period;
                r_seen     <= '0;
                r_samp_pos <= '0;
                r_diff_pos <= '0;
                r_full_f   <= '0;
                r_half_f   <= '0;
                r_root_f   <= '0;
                r_full_w   <= '0;
                r_half_w   <= '0;
                r_root_w   <= '0;
            end
            if (i_cmd.load) begin
                r_x <= i_sample;
                r_i <= r_seen;
            end
            if (i_cmd.warm || i_cmd.acc) begin
                r_full_w <= r_full_w + WSUM_BITS'(p_a);
                r_full_f <= r_full_f + FLAT_BITS'(r_x);
                if (i_cmd.acc || half_in) begin
                    r_half_w <= r_half_w + WSUM_BITS'(p_b);
                    r_half_f <= r_half_f + FLAT_BITS'(r_x);
                end
            end
            if (i_cmd.cap_full) r_wma_full <= div_q[SAMPLE_BITS-1:0];
            if (i_cmd.cap_half) r_wma_half <= div_q[SAMPLE_BITS-1:0];
            if (i_cmd.diff) begin
                r_diff   <= d;
                r_root_w <= r_root_w + WSUM_BITS'(p_d);
                r_root_f <= r_root_f + FLAT_BITS'(d);
            end
            // a new result replaces the one taken on the same edge
            if (i_cmd.emit) begin
                r_out_value <= sat(div_q);
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_root_w <= r_root_w - WSUM_BITS'(r_root_f);
                if (o_status.emit) r_root_f <= r_root_f - FLAT_BITS'(diff_old);
                r_full_w   <= r_full_w - WSUM_BITS'(r_full_f);
                r_full_f   <= r_full_f - FLAT_BITS'(r_old_full);
                r_half_w   <= r_half_w - WSUM_BITS'(r_half_f);
                r_half_f   <= r_half_f - FLAT_BITS'(half_old);
                r_diff_pos <= r_diff_pos + ROOT_ADDR_BITS'(1);
            end
            if (i_cmd.warm || i_cmd.fin) begin
                r_samp_pos <= r_samp_pos + ADDR_BITS'(1);
                if (r_seen != SEEN_BITS'(SEEN_CAP)) r_seen <= r_seen + SEEN_BITS'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;

endmodule

// ----- sv/hma_ctrl.sv -----
// controller state machine sequencing one item through the datapath
module hma_ctrl import hma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_stall,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_cfg_valid && i_sample_valid) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = i_status.warm ? S_IDLE : S_DF_GO;
            end
            S_DF_GO:   n_state = S_DF_WAIT;
            S_DF_WAIT: begin
                if (i_status.div_done) n_state = S_DH_GO;
            end
            S_DH_GO:   n_state = S_DH_WAIT;
            S_DH_WAIT: begin
                if (i_status.div_done) n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = i_status.emit ? S_DR_GO : S_FIN;
            end
            S_DR_GO:   n_state = S_DR_WAIT;
            S_DR_WAIT: begin
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) n_state = S_FIN;
            end
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.div_sel  = DIV_FULL;
        o_sample_stall = 1'b1;
        o_cfg_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready    = 1'b1;
                o_sample_stall = i_cfg_valid;
                o_cmd.cfg_we   = i_cfg_valid;
                o_cmd.load     = !i_cfg_valid && i_sample_valid;
            end
            S_UPD: begin
                o_cmd.warm = i_status.warm;
                o_cmd.acc  = !i_status.warm;
            end
            S_DF_GO:   o_cmd.div_go = 1'b1;
            S_DF_WAIT: o_cmd.cap_full = i_status.div_done;
            S_DH_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_HALF;
            end
            S_DH_WAIT: o_cmd.cap_half = i_status.div_done;
            S_DIFF:    o_cmd.diff = 1'b1;
            S_DR_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_ROOT;
            end
            S_DR_WAIT: o_cmd.div_sel = DIV_ROOT;
            S_OUT:     o_cmd.emit = i_status.out_free;
            S_FIN:     o_cmd.fin = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ----- sv/hull_moving_average.sv -----
// top level of the streaming hull moving average block
// Streaming Hull moving average over signed Q16.16 samples. Each item on the
// sample channel updates the running sums of WMA(N) and WMA(N/2), forms
// diff = 2*WMA(N/2) - WMA(N) and feeds it to a WMA over floor(sqrt N) diffs;
// the result, saturated to 32 bits, comes out once N+floor(sqrt N)-1 items
// have arrived since reset or the last period write, one result per item
// from then on. Writing the period restarts the stream. Items are taken
// one at a time; once warm-up is over each goes through the shared
// divider, which serves all three averages in turn, and an item that
// yields a result waits while the result side stalls. A new item is
// taken while a finished result still waits in the output register.
module hull_moving_average import hma_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_sample_valid,
    output logic                          o_sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                          o_hma_valid,
    input  logic                          i_hma_stall,
    output logic signed [SAMPLE_BITS-1:0] o_hma_value,
    // period register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [PERIOD_BITS-1:0]        i_cfg_period
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    hma_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    hma_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_period (i_cfg_period),
        .i_sample     (i_sample),
        .i_out_stall  (i_hma_stall),
        .o_out_valid  (o_hma_valid),
        .o_out_value  (o_hma_value)
    );

    // an item and a period write never land on the same edge
    a_cfg_vs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_sample_valid && !o_sample_stall && i_cfg_valid && o_cfg_ready))
        else $error("item accepted together with period write");

    // one item at a time: the channel closes right after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && !o_sample_stall) |=> o_sample_stall)
        else $error("second item accepted while one is in work");

    // a result is only formed while an item is in work
    a_result_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_hma_valid) |-> $past(o_sample_stall))
        else $error("result appeared with no item in work");

endmodule
